>>> src/gmfw_pkg.sv
// gmfw_pkg: shared types, constants and calendar helpers for the month
// first-weekday unit and its checker. No dependencies.
`default_nettype none

package gmfw_pkg;

    // year range accepted by the unit
    localparam logic [13:0] FIRST_YEAR = 14'd1753;
    localparam logic [13:0] MAX_YEAR   = 14'd9999;

    // first year's position in the 100 and 400 year cycles
    localparam logic [6:0] FIRST_C100 = 7'd53;
    localparam logic [8:0] FIRST_C400 = 9'd153;
    localparam logic [6:0] LAST_C100  = 7'd99;
    localparam logic [8:0] LAST_C400  = 9'd399;

    // month codes
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // day count modulus
    localparam logic [3:0] DAYS_PER_WEEK = 4'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YEARS,
        ST_MONTHS
    } t_state;

    // add a small step to a weekday residue, result modulo 7
    function automatic logic [2:0] mod7_add(input logic [2:0] a, input logic [1:0] b);
        logic [3:0] s;
        s = {1'b0, a} + {2'b00, b};
        if (s >= DAYS_PER_WEEK) begin
            s = s - DAYS_PER_WEEK;
        end
        return s[2:0];
    endfunction

    // days in a month, month in 1..12
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            MONTH_FEB: d = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

    // month length modulo 7
    function automatic logic [1:0] month_step(input logic [3:0] m, input logic leap);
        logic [1:0] s;
        unique case (m)
            MONTH_FEB: s = leap ? 2'd1 : 2'd0;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: s = 2'd2;
            default: s = 2'd3;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> src/gregorian_month_first_weekday_unit.sv
// gregorian_month_first_weekday_unit: top level, walks years then months
// through one shared modulo-7 adder. Depends on gmfw_pkg.
`default_nettype none

//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_month_number, i_year_number
//  out      | output    | o_out_valid / i_out_stall | o_first_weekday, o_month_length,
//           |           |                           | o_leap_flag, o_range_error
//
// a valid beat walks the years from 1753 up to the query year, then the months from
// January up to the query month, and then finishes, all through the single modulo-7 adder
// an out-of-range beat gives its error result in the next cycle
// a finished result sits in the output register; a new beat is stalled while it is stalled
// reset is synchronous, active low, and clears control and walk state
module gregorian_month_first_weekday_unit
    import gmfw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_month_number,
    input  wire logic [13:0] i_year_number,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_first_weekday,
    output logic [4:0]       o_month_length,
    output logic             o_leap_flag,
    output logic             o_range_error
);

    t_state      r_state, n_state;
    logic [13:0] r_year_walk, n_year_walk;
    logic [2:0]  r_weekday_sum, n_weekday_sum;
    logic [3:0]  r_month_walk, n_month_walk;
    logic [6:0]  r_c100, n_c100;
    logic [8:0]  r_c400, n_c400;
    logic [13:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_first_weekday, n_first_weekday;
    logic [4:0]  r_month_length, n_month_length;
    logic        r_leap_flag, n_leap_flag;
    logic        r_range_error, n_range_error;

    logic        in_beat;
    logic        in_bad;
    logic        slot_free;
    logic        walk_leap;
    logic        years_done;
    logic        months_done;
    logic [1:0]  add_step;
    logic [2:0]  add_sum;

    // handshake and status terms
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE) || !slot_free;
    assign in_beat     = i_in_valid && !o_in_stall;
    assign in_bad      = (i_month_number < MONTH_JAN) || (i_month_number > MONTH_DEC) ||
                         (i_year_number < FIRST_YEAR) || (i_year_number > MAX_YEAR);
    assign walk_leap   = (r_year_walk[1:0] == 2'b00) && ((r_c100 != '0) || (r_c400 == '0));
    assign years_done  = (r_year_walk == r_year);
    assign months_done = (r_month_walk == r_month);

    // shared modulo-7 adder, step chosen by phase
    always_comb begin
        unique case (r_state)
            ST_YEARS:  add_step = walk_leap ? 2'd2 : 2'd1;
            ST_MONTHS: add_step = months_done ? 2'd1 : month_step(r_month_walk, walk_leap);
            default:   add_step = 2'd0;
        endcase
    end
    assign add_sum = mod7_add(r_weekday_sum, add_step);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat && !in_bad) begin
                    n_state = ST_YEARS;
                end
            end
            ST_YEARS: begin
                if (years_done) begin
                    n_state = ST_MONTHS;
                end
            end
            ST_MONTHS: begin
                if (months_done && slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb begin
        n_year_walk     = r_year_walk;
        n_weekday_sum   = r_weekday_sum;
        n_month_walk    = r_month_walk;
        n_c100          = r_c100;
        n_c400          = r_c400;
        n_year          = r_year;
        n_month         = r_month;
        n_out_valid     = r_out_valid && i_out_stall;
        n_first_weekday = r_first_weekday;
        n_month_length  = r_month_length;
        n_leap_flag     = r_leap_flag;
        n_range_error   = r_range_error;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat && in_bad) begin
                    n_out_valid     = 1'b1;
                    n_first_weekday = '0;
                    n_month_length  = '0;
                    n_leap_flag     = 1'b0;
                    n_range_error   = 1'b1;
                end else if (in_beat) begin
                    n_year        = i_year_number;
                    n_month       = i_month_number;
                    n_year_walk   = FIRST_YEAR;
                    n_c100        = FIRST_C100;
                    n_c400        = FIRST_C400;
                    n_weekday_sum = '0;
                end
            end
            ST_YEARS: begin
                if (years_done) begin
                    n_month_walk = MONTH_JAN;
                end else begin
                    n_weekday_sum = add_sum;
                    n_year_walk   = r_year_walk + 14'd1;
                    n_c100        = (r_c100 == LAST_C100) ? '0 : r_c100 + 7'd1;
                    n_c400        = (r_c400 == LAST_C400) ? '0 : r_c400 + 9'd1;
                end
            end
            ST_MONTHS: begin
                if (!months_done) begin
                    n_weekday_sum = add_sum;
                    n_month_walk  = r_month_walk + 4'd1;
                end else if (slot_free) begin
                    n_out_valid     = 1'b1;
                    n_first_weekday = add_sum;
                    n_month_length  = month_days(r_month, walk_leap);
                    n_leap_flag     = walk_leap;
                    n_range_error   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_year_walk   <= '0;
            r_weekday_sum <= '0;
            r_month_walk  <= '0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_year_walk   <= n_year_walk;
            r_weekday_sum <= n_weekday_sum;
            r_month_walk  <= n_month_walk;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_c100          <= n_c100;
        r_c400          <= n_c400;
        r_year          <= n_year;
        r_month         <= n_month;
        r_first_weekday <= n_first_weekday;
        r_month_length  <= n_month_length;
        r_leap_flag     <= n_leap_flag;
        r_range_error   <= n_range_error;
    end

    assign o_out_valid     = r_out_valid;
    assign o_first_weekday = r_first_weekday;
    assign o_month_length  = r_month_length;
    assign o_leap_flag     = r_leap_flag;
    assign o_range_error   = r_range_error;

endmodule

`default_nettype wire

>>> src/gmfw_checker.sv
// gmfw_checker: port-level assertions for the month first-weekday unit,
// bound to the top level. Depends on gmfw_pkg.
`default_nettype none

module gmfw_checker
    import gmfw_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [3:0]  i_month_number,
    input wire logic [13:0] i_year_number,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_first_weekday,
    input wire logic [4:0]  o_month_length,
    input wire logic        o_leap_flag,
    input wire logic        o_range_error
);

    // out-of-range query gives an error beat straight away
    a_bad_query_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall &&
         ((i_month_number < MONTH_JAN) || (i_month_number > MONTH_DEC) ||
          (i_year_number < FIRST_YEAR) || (i_year_number > MAX_YEAR)))
        |=> (o_out_valid && o_range_error))
        else $error("out-of-range query did not give an error beat");

    // good result fields stay in range
    a_good_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_range_error)
        |-> (o_first_weekday < 3'd7) && (o_month_length >= 5'd28) &&
            (o_month_length <= 5'd31))
        else $error("result field out of range");

    // error beat carries zeros
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error)
        |-> (o_first_weekday == '0) && (o_month_length == '0) && !o_leap_flag)
        else $error("error beat with non-zero fields");

    // a 29-day month only in a leap year
    a_leap_feb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_month_length == 5'd29)) |-> o_leap_flag)
        else $error("29-day month without leap flag");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
        |=> (o_out_valid && $stable(o_first_weekday) && $stable(o_month_length) &&
             $stable(o_leap_flag) && $stable(o_range_error)))
        else $error("stalled result changed");

endmodule

bind gregorian_month_first_weekday_unit gmfw_checker u_gmfw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_month_number  (i_month_number),
    .i_year_number   (i_year_number),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_first_weekday (o_first_weekday),
    .o_month_length  (o_month_length),
    .o_leap_flag     (o_leap_flag),
    .o_range_error   (o_range_error)
);

`default_nettype wire

>>> tb/sv/month_weekday_check.sv
`timescale 1ns / 100ps
// month_weekday_check: watches both channels of the month first-weekday unit,
// works out the answer to each query and compares it field by field.
// Depends on gmfw_pkg for the year limits and the month codes.

module month_weekday_check
    import gmfw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [3:0]  i_month_number,
    input  wire logic [13:0] i_year_number,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_first_weekday,
    input  wire logic [4:0]  i_month_length,
    input  wire logic        i_leap_flag,
    input  wire logic        i_range_error,
    output int               o_fail_count,
    output int               o_outstanding,
    output int               o_answers_seen,
    output int               o_rejects_seen
);

    typedef struct packed {
        logic [2:0] weekday;
        logic [4:0] days;
        logic       leap;
        logic       bad;
    } t_month_answer;

    // answers still owed by the unit, oldest first
    t_month_answer pending_answers[$];

    // where the last valid walk ended; the sum is 0 for a monday
    logic [13:0] walk_year  = '0;
    logic [3:0]  walk_month = '0;
    logic [2:0]  walk_sum   = '0;

    int fails   = 0;
    int answers = 0;
    int rejects = 0;

    function automatic bit leap_year_of(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic logic [4:0] days_of(input logic [3:0] m, input bit leap);
        if (m == MONTH_FEB) begin
            return leap ? 5'd29 : 5'd28;
        end
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
            return 5'd30;
        end
        return 5'd31;
    endfunction

    // answer to one query; a query in range also moves the walk state
    task automatic work_out_month(input logic [3:0] m, input logic [13:0] y,
                                  output t_month_answer a);
        int unsigned yr;
        int unsigned sum;
        logic [3:0]  mo;
        a = '0;
        if (m < MONTH_JAN || m > MONTH_DEC || y < FIRST_YEAR || y > MAX_YEAR) begin
            a.bad = 1'b1;
            return;
        end
        sum = 0;
        for (yr = FIRST_YEAR; yr < y; yr++) begin
            sum = (sum + (leap_year_of(yr) ? 366 : 365)) % DAYS_PER_WEEK;
        end
        for (mo = MONTH_JAN; mo < m; mo++) begin
            sum = (sum + days_of(mo, leap_year_of(y))) % DAYS_PER_WEEK;
        end
        walk_year  = yr[13:0];
        walk_month = mo;
        walk_sum   = sum[2:0];
        // shift from a monday-based count to sunday as zero
        a.weekday  = 3'((walk_sum + 32'd1) % DAYS_PER_WEEK);
        a.days     = days_of(m, leap_year_of(y));
        a.leap     = leap_year_of(y);
    endtask

    always @(posedge i_clk) begin
        t_month_answer want;
        t_month_answer got;
        if (!i_rst_n) begin
            pending_answers.delete();
            walk_year  = '0;
            walk_month = '0;
            walk_sum   = '0;
        end else begin
            // result beat against the oldest answer owed
            if (i_out_valid && !i_out_stall) begin
                got = '{i_first_weekday, i_month_length, i_leap_flag, i_range_error};
                if (pending_answers.size() == 0) begin
                    $error("result beat with no query waiting: weekday %0d length %0d",
                           got.weekday, got.days);
                    fails++;
                end else begin
                    want = pending_answers.pop_front();
                    answers++;
                    if (want.bad) begin
                        rejects++;
                    end
                    if (got.weekday !== want.weekday) begin
                        $error("first_weekday: expected %0d, got %0d", want.weekday, got.weekday);
                        fails++;
                    end
                    if (got.days !== want.days) begin
                        $error("month_length: expected %0d, got %0d", want.days, got.days);
                        fails++;
                    end
                    if (got.leap !== want.leap) begin
                        $error("leap_flag: expected %0d, got %0d", want.leap, got.leap);
                        fails++;
                    end
                    if (got.bad !== want.bad) begin
                        $error("range_error: expected %0d, got %0d", want.bad, got.bad);
                        fails++;
                    end
                end
            end
            // query beat: work out what the unit owes for it
            if (i_in_valid && !i_in_stall) begin
                work_out_month(i_month_number, i_year_number, want);
                pending_answers.push_back(want);
            end
        end
        o_fail_count   <= fails;
        o_outstanding  <= pending_answers.size();
        o_answers_seen <= answers;
        o_rejects_seen <= rejects;
    end

endmodule

>>> tb/sv/tb_gregorian_month_first_weekday_unit.sv
`timescale 1ns / 100ps
// tb_gregorian_month_first_weekday_unit: drives month and year queries into the
// unit with random gaps and output stalls; month_weekday_check does the checking.
// Depends on gmfw_pkg, the unit and month_weekday_check.

module tb_gregorian_month_first_weekday_unit;
    import gmfw_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int CYCLE_LIMIT    = 6_000_000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_QUERIES = 80;
    localparam int QUIET_FROM     = 64;

    localparam logic [3:0]  NO_MONTH       = 4'd0;
    localparam logic [3:0]  TOP_MONTH_CODE = 4'hF;
    localparam logic [13:0] TOP_YEAR_CODE  = 14'h3FFF;

    logic        i_clk        = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic [3:0]  month_number = '0;
    logic [13:0] year_number  = '0;
    logic        out_stall    = 1'b0;
    logic        quiet        = 1'b0;

    wire logic       in_stall;
    wire logic       out_valid;
    wire logic [2:0] first_weekday;
    wire logic [4:0] month_length;
    wire logic       leap_flag;
    wire logic       range_error;

    int fail_count;
    int outstanding;
    int answers_seen;
    int rejects_seen;
    int stall_left    = 0;
    int cycle_count   = 0;
    int latest_year   = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    gregorian_month_first_weekday_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_month_number  (month_number),
        .i_year_number   (year_number),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_first_weekday (first_weekday),
        .o_month_length  (month_length),
        .o_leap_flag     (leap_flag),
        .o_range_error   (range_error)
    );

    month_weekday_check u_month_check (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_month_number  (month_number),
        .i_year_number   (year_number),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_first_weekday (first_weekday),
        .i_month_length  (month_length),
        .i_leap_flag     (leap_flag),
        .i_range_error   (range_error),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_answers_seen  (answers_seen),
        .o_rejects_seen  (rejects_seen)
    );

    // receiver stalls in random bursts, none once the quiet phase starts
    always @(posedge i_clk) begin
        if (quiet || stall_left == 0) begin
            out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 19);
            end
        end else begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one query beat, held until taken, then maybe a gap
    task automatic send_query(input logic [3:0] m, input logic [13:0] y);
        in_valid     <= 1'b1;
        month_number <= m;
        year_number  <= y;
        do @(posedge i_clk); while (in_stall);
        if (m >= MONTH_JAN && m <= MONTH_DEC && y >= FIRST_YEAR && y <= MAX_YEAR
            && y > latest_year) begin
            latest_year = int'(y);
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    initial begin
        int          kind;
        logic [3:0]  m;
        logic [13:0] y;
        logic [3:0]  mo;

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // every month of the first year
        for (mo = MONTH_JAN; mo <= MONTH_DEC; mo++) begin
            send_query(mo, FIRST_YEAR);
        end
        // leap rules: ordinary leap year, plain century, fourth century, last year
        send_query(MONTH_FEB, 14'd1756);
        send_query(MONTH_FEB, 14'd1800);
        send_query(MONTH_FEB, 14'd2000);
        send_query(MONTH_DEC, MAX_YEAR);
        // out of range months and years on both sides
        send_query(NO_MONTH, 14'd2000);
        send_query(MONTH_DEC + 4'd1, 14'd2000);
        send_query(TOP_MONTH_CODE, TOP_YEAR_CODE);
        send_query(MONTH_JAN, FIRST_YEAR - 14'd1);
        send_query(MONTH_JAN, MAX_YEAR + 14'd1);
        send_query(NO_MONTH, 14'd0);

        // hold off until the unit has drained
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);

        // random queries, mostly valid and close to the first year
        for (int n = 0; n < RANDOM_QUERIES; n++) begin
            if (n == QUIET_FROM) begin
                quiet <= 1'b1;
            end
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                m = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
                y = 14'($urandom_range(FIRST_YEAR, FIRST_YEAR + 600));
            end else if (kind < 15) begin
                m = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
                y = 14'($urandom_range(FIRST_YEAR, MAX_YEAR));
            end else if (kind == 15) begin
                m = 4'($urandom_range(0, 3));
                if (m != NO_MONTH) begin
                    m = m + MONTH_DEC;
                end
                y = 14'($urandom_range(0, TOP_YEAR_CODE));
            end else if (kind == 16) begin
                m = 4'($urandom_range(0, TOP_MONTH_CODE));
                y = 14'($urandom_range(0, FIRST_YEAR - 1));
            end else if (kind == 17) begin
                m = 4'($urandom_range(0, TOP_MONTH_CODE));
                y = 14'($urandom_range(MAX_YEAR + 1, TOP_YEAR_CODE));
            end else begin
                m = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
                case ($urandom_range(0, 3))
                    0: y = FIRST_YEAR - 14'd1;
                    1: y = FIRST_YEAR;
                    2: y = MAX_YEAR;
                    default: y = MAX_YEAR + 14'd1;
                endcase
            end
            send_query(m, y);
        end

        // drain, then let any stray beat show up
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("checked %0d answers, %0d of them range rejections",
                 answers_seen, rejects_seen);
        $display("months and years drawn across their full codes, latest valid year %0d",
                 latest_year);
        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
